FILE: src/uvst_pkg.sv
// Shared types and constants for the UV sphere tessellator.
`timescale 1ns / 1ps
package uvst_pkg;
	localparam int MAX_GRID_SIZE_DEF    = 256;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 2'd2;

	localparam logic [8:0]  RING_COUNT_RST    = 9'd16;
	localparam logic [8:0]  SEGMENT_COUNT_RST = 9'd16;
	localparam logic [15:0] SPHERE_RADIUS_RST = 16'd256;

	typedef struct packed {
		logic [15:0] this_pt;
		logic [15:0] down_pt;
		logic [15:0] diag_pt;
		logic [15:0] side_pt;
	} tri_idx_t;
endpackage

FILE: src/uv_sphere_tessellator.sv
// UV sphere tessellator top level: config registers, front end, queue, back end.
//
// Input channel: in_valid/in_stall with ring_index and segment_index naming one
// grid point. Output channel: out_valid/out_stall with the vertex position in
// signed Q8.8 and the six indices of the two triangles anchored at that point.
// A transaction moves when valid is high and stall is low.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (ring count, segment count, radius); write only while the block is idle.
// Throughput: one transaction per cycle in each direction while neither side
// stalls. Between input and output lie the front end's pipelined long dividers
// (log2(SINE_TABLE_DEPTH)+10 stages), the queue and the six-stage back end
// (table read, two multiplies, rounding).
// Reset clears all pipelines and the queue and loads the default registers; no
// clearing pass, the block takes input in the first cycle after reset.
// When the receiver stalls, the back end holds its result and freezes; the front
// end keeps working until the queue credit runs out, then raises in_stall.
`timescale 1ns / 1ps
module uv_sphere_tessellator #(
	parameter int MAX_GRID_SIZE    = uvst_pkg::MAX_GRID_SIZE_DEF,
	parameter int SINE_TABLE_DEPTH = uvst_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [uvst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uvst_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     ring_index,
	input  logic [7:0]                     segment_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [15:0]                    vertex_x,
	output logic [15:0]                    vertex_y,
	output logic [15:0]                    vertex_z,
	output logic [15:0]                    tri_a0,
	output logic [15:0]                    tri_a1,
	output logic [15:0]                    tri_a2,
	output logic [15:0]                    tri_b0,
	output logic [15:0]                    tri_b1,
	output logic [15:0]                    tri_b2
);
	import uvst_pkg::*;

	localparam int DW      = $clog2(SINE_TABLE_DEPTH);
	localparam int Q_DEPTH = 2 ** $clog2(DW + 13);
	localparam int QW      = 2 * DW + $bits(tri_idx_t);

	logic [8:0]    ring_count_q, segment_count_q;
	logic [15:0]   sphere_radius_q;
	logic          push, pop, q_valid;
	logic [DW-1:0] f_pol, f_azi, b_pol, b_azi;
	tri_idx_t      f_idx, b_idx, o_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= RING_COUNT_RST;
			segment_count_q <= SEGMENT_COUNT_RST;
			sphere_radius_q <= SPHERE_RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RING_COUNT:    ring_count_q    <= cfg_data[8:0];
				CFG_SEGMENT_COUNT: segment_count_q <= cfg_data[8:0];
				CFG_SPHERE_RADIUS: sphere_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	uvst_front #(
		.MAX_GRID(MAX_GRID_SIZE), .D(SINE_TABLE_DEPTH), .Q_DEPTH(Q_DEPTH)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ring_index(ring_index), .segment_index(segment_index),
		.ring_count(ring_count_q), .segment_count(segment_count_q),
		.pop(pop), .push(push),
		.pol_step(f_pol), .azi_step(f_azi), .tri_idx(f_idx)
	);

	uvst_fifo #(.W(QW), .DEPTH(Q_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({f_pol, f_azi, f_idx}),
		.pop(pop), .rdata({b_pol, b_azi, b_idx}), .valid(q_valid)
	);

	uvst_back #(.D(SINE_TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .pop(pop),
		.pol_step(b_pol), .azi_step(b_azi), .tri_idx(b_idx),
		.sphere_radius(sphere_radius_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.tri_out(o_idx)
	);

	assign tri_a0 = o_idx.this_pt;
	assign tri_a1 = o_idx.down_pt;
	assign tri_a2 = o_idx.diag_pt;
	assign tri_b0 = o_idx.diag_pt;
	assign tri_b1 = o_idx.side_pt;
	assign tri_b2 = o_idx.this_pt;
endmodule

FILE: src/uvst_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module uvst_div #(
	parameter int NW  = 20,
	parameter int DVW = 10,
	parameter int QW  = 10
) (
	input  logic           clk,
	input  logic [NW-1:0]  num,
	input  logic [DVW-1:0] den,
	output logic [QW-1:0]  quo,
	output logic [DVW-1:0] rem
);
	logic [DVW-1:0] rem_q [NW];
	logic [DVW-1:0] den_q [NW];
	logic [NW-1:0]  num_q [NW];
	logic [QW-1:0]  quo_q [NW];

	logic [DVW-1:0] rem_in [NW];
	logic [DVW-1:0] den_in [NW];
	logic [NW-1:0]  num_in [NW];
	logic [QW-1:0]  quo_in [NW];
	logic [DVW:0]   cand   [NW];
	logic [DVW:0]   diff   [NW];
	logic           ge     [NW];

	always_comb begin
		for (int t = 0; t < NW; t++) begin
			if (t == 0) begin
				rem_in[t] = '0;
				den_in[t] = den;
				num_in[t] = num;
				quo_in[t] = '0;
			end else begin
				rem_in[t] = rem_q[t-1];
				den_in[t] = den_q[t-1];
				num_in[t] = num_q[t-1];
				quo_in[t] = quo_q[t-1];
			end
			cand[t] = {rem_in[t], num_in[t][NW-1]};
			ge[t]   = cand[t] >= {1'b0, den_in[t]};
			diff[t] = cand[t] - {1'b0, den_in[t]};
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NW; t++) begin
			rem_q[t] <= ge[t] ? diff[t][DVW-1:0] : cand[t][DVW-1:0];
			den_q[t] <= den_in[t];
			num_q[t] <= {num_in[t][NW-2:0], 1'b0};
			quo_q[t] <= {quo_in[t][QW-2:0], ge[t]};
		end
	end

	assign quo = quo_q[NW-1];
	assign rem = rem_q[NW-1];
endmodule

FILE: src/uvst_front.sv
// Front end: accepts grid points, computes angle steps and triangle indices.
`timescale 1ns / 1ps
module uvst_front #(
	parameter int MAX_GRID = 256,
	parameter int D        = 1024,
	parameter int Q_DEPTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           ring_index,
	input  logic [7:0]           segment_index,
	input  logic [8:0]           ring_count,
	input  logic [8:0]           segment_count,
	input  logic                 pop,
	output logic                 push,
	output logic [$clog2(D)-1:0] pol_step,
	output logic [$clog2(D)-1:0] azi_step,
	output uvst_pkg::tri_idx_t   tri_idx
);
	import uvst_pkg::*;

	localparam int DW  = $clog2(D);
	localparam int NW  = DW + 10;
	localparam int DVW = 10;
	localparam int OW  = $clog2(Q_DEPTH + 1);

	logic [8:0]     rc_eff, sc_eff;
	logic           accept;
	logic [OW-1:0]  occ_q;
	logic [NW-1:0]  pk_num, mk_num, nj_num, ni_num;
	logic [DVW-1:0] pk_den, mk_den, nj_den, ni_den;
	logic [DVW-1:0] nj_rem, ni_rem;
	logic           vld_q [NW];
	logic [7:0]     j_q   [NW];
	logic [7:0]     i_q   [NW];
	logic [8:0]     sc_q  [NW];
	logic [7:0]     nj, ni;
	logic [16:0]    row_j, row_nj;

	always_comb begin
		priority if (ring_count < 9'd2) rc_eff = 9'd2;
		else if (ring_count > 9'(MAX_GRID)) rc_eff = 9'(MAX_GRID);
		else rc_eff = ring_count;
		priority if (segment_count < 9'd3) sc_eff = 9'd3;
		else if (segment_count > 9'(MAX_GRID)) sc_eff = 9'(MAX_GRID);
		else sc_eff = segment_count;
	end

	// credit covers everything in flight plus the queue
	assign in_stall = occ_q == OW'(Q_DEPTH);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OW'(accept) - OW'(pop);
		end
	end

	assign pk_num = (NW'(ring_index) << DW) + NW'(rc_eff - 9'd1);
	assign pk_den = {rc_eff - 9'd1, 1'b0};
	assign mk_num = (NW'(segment_index) << (DW + 1)) + NW'(sc_eff);
	assign mk_den = {sc_eff, 1'b0};
	assign nj_num = NW'(ring_index) + NW'(1);
	assign nj_den = {1'b0, rc_eff};
	assign ni_num = NW'(segment_index) + NW'(1);
	assign ni_den = {1'b0, sc_eff};

	uvst_div #(.NW(NW), .DVW(DVW), .QW(DW)) u_div_pol (
		.clk(clk), .num(pk_num), .den(pk_den), .quo(pol_step), .rem()
	);
	uvst_div #(.NW(NW), .DVW(DVW), .QW(DW)) u_div_azi (
		.clk(clk), .num(mk_num), .den(mk_den), .quo(azi_step), .rem()
	);
	uvst_div #(.NW(NW), .DVW(DVW), .QW(DW)) u_div_nj (
		.clk(clk), .num(nj_num), .den(nj_den), .quo(), .rem(nj_rem)
	);
	uvst_div #(.NW(NW), .DVW(DVW), .QW(DW)) u_div_ni (
		.clk(clk), .num(ni_num), .den(ni_den), .quo(), .rem(ni_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NW; t++) vld_q[t] <= 1'b0;
		end else begin
			vld_q[0] <= accept;
			for (int t = 1; t < NW; t++) vld_q[t] <= vld_q[t-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NW; t++) begin
			if (t == 0) begin
				j_q[t]  <= ring_index;
				i_q[t]  <= segment_index;
				sc_q[t] <= sc_eff;
			end else begin
				j_q[t]  <= j_q[t-1];
				i_q[t]  <= i_q[t-1];
				sc_q[t] <= sc_q[t-1];
			end
		end
	end

	assign nj     = nj_rem[7:0];
	assign ni     = ni_rem[7:0];
	assign row_j  = 17'(j_q[NW-1]) * 17'(sc_q[NW-1]);
	assign row_nj = 17'(nj) * 17'(sc_q[NW-1]);
	assign push   = vld_q[NW-1];

	assign tri_idx.this_pt = 16'(row_j + 17'(i_q[NW-1]));
	assign tri_idx.down_pt = 16'(row_nj + 17'(i_q[NW-1]));
	assign tri_idx.diag_pt = 16'(row_nj + 17'(ni));
	assign tri_idx.side_pt = 16'(row_j + 17'(ni));
endmodule

FILE: src/uvst_fifo.sv
// Queue between front and back ends.
`timescale 1ns / 1ps
module uvst_fifo #(
	parameter int W     = 84,
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         valid
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign valid = count_q != '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CW'(DEPTH))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue pop while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CW'($past(push)) - CW'($past(pop)))
		else $error("queue count mismatch");
endmodule

FILE: src/uvst_back.sv
// Back end: sine table lookup, scaling by radius, rounding and saturation.
`timescale 1ns / 1ps
module uvst_back #(
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 pop,
	input  logic [$clog2(D)-1:0] pol_step,
	input  logic [$clog2(D)-1:0] azi_step,
	input  uvst_pkg::tri_idx_t   tri_idx,
	input  logic [15:0]          sphere_radius,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          vertex_x,
	output logic [15:0]          vertex_y,
	output logic [15:0]          vertex_z,
	output uvst_pkg::tri_idx_t   tri_out
);
	import uvst_pkg::*;

	localparam int DW   = $clog2(D);
	localparam int TW   = DW - 2;
	localparam int ROMN = D / 8 + 1;
	localparam longint unsigned PI4_Q30 = 64'd843314857;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	// sin/cos of one octant step in Q2.14, truncated Taylor series in Q2.30
	function automatic logic [31:0] trig_entry(input int unsigned n);
		longint unsigned num, x, x2, x3, x4, x5, x6, x7, x8, sv, cv, ps, pc;
		num = 64'(n) * 64'd8;
		x   = (num * PI4_Q30 + 64'(D / 2)) >> DW;
		x2  = (x * x) >> 30;
		x3  = (x2 * x) >> 30;
		x4  = (x3 * x) >> 30;
		x5  = (x4 * x) >> 30;
		x6  = (x5 * x) >> 30;
		x7  = (x6 * x) >> 30;
		x8  = (x7 * x) >> 30;
		sv  = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
		cv  = ONE_Q30 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
		ps  = (sv + 64'd32768) >> 16;
		pc  = (cv + 64'd32768) >> 16;
		return {ps[15:0], pc[15:0]};
	endfunction

	function automatic logic [31:0] apply_oct(input logic [2:0] oct, input logic [31:0] ent);
		logic [15:0] ps, pc;
		logic [31:0] sc;
		ps = ent[31:16];
		pc = ent[15:0];
		unique case (oct)
			3'd0: sc = {ps, pc};
			3'd1: sc = {pc, ps};
			3'd2: sc = {pc, 16'(-ps)};
			3'd3: sc = {ps, 16'(-pc)};
			3'd4: sc = {16'(-ps), 16'(-pc)};
			3'd5: sc = {16'(-pc), 16'(-ps)};
			3'd6: sc = {16'(-pc), ps};
			3'd7: sc = {16'(-ps), pc};
		endcase
		return sc;
	endfunction

	// round half away from zero, saturate to signed 16 bits
	function automatic logic [15:0] round_sat(input logic signed [48:0] p,
			input int unsigned sh);
		logic        neg;
		logic [48:0] m, r;
		logic [15:0] v;
		neg = p[48];
		m   = neg ? 49'(-p) : 49'(p);
		r   = (m + (49'(1) << (sh - 1))) >> sh;
		if (neg) v = (r > 49'd32768) ? 16'h8000 : 16'(49'd0 - r);
		else v = (r > 49'd32767) ? 16'h7FFF : r[15:0];
		return v;
	endfunction

	logic [31:0] rom [ROMN];
	for (genvar g = 0; g < ROMN; g++) begin : g_rom
		assign rom[g] = trig_entry(g);
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_vld_q;

	logic [2:0]        oct_p, oct_m;
	logic [TW-1:0]     tidx_p, tidx_m;
	logic [2:0]        oct_p_s1, oct_m_s1, oct_p_s2, oct_m_s2;
	logic [TW-1:0]     tidx_p_s1, tidx_m_s1;
	logic [31:0]       ent_p_s2, ent_m_s2;
	logic [31:0]       scp, scm;
	logic signed [15:0] sp_s3, cp_s3, sm_s3, cm_s3, sm_s4, cm_s4;
	logic signed [32:0] rs_s4, rz_s4, rz_s5;
	logic signed [48:0] px_s5, py_s5;
	tri_idx_t          idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_q;
	logic [15:0]       x_q, y_q, z_q;

	assign en  = !out_vld_q || !out_stall;
	assign pop = en && q_valid;

	assign oct_p  = pol_step[DW-1:DW-3];
	assign oct_m  = azi_step[DW-1:DW-3];
	assign tidx_p = oct_p[0] ? TW'(D / 8) - TW'(pol_step[DW-4:0]) : TW'(pol_step[DW-4:0]);
	assign tidx_m = oct_m[0] ? TW'(D / 8) - TW'(azi_step[DW-4:0]) : TW'(azi_step[DW-4:0]);

	assign scp = apply_oct(oct_p_s2, ent_p_s2);
	assign scm = apply_oct(oct_m_s2, ent_m_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= q_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_vld_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oct_p_s1  <= oct_p;
			oct_m_s1  <= oct_m;
			tidx_p_s1 <= tidx_p;
			tidx_m_s1 <= tidx_m;
			idx_s1    <= tri_idx;

			oct_p_s2  <= oct_p_s1;
			oct_m_s2  <= oct_m_s1;
			ent_p_s2  <= rom[tidx_p_s1];
			ent_m_s2  <= rom[tidx_m_s1];
			idx_s2    <= idx_s1;

			sp_s3     <= scp[31:16];
			cp_s3     <= scp[15:0];
			sm_s3     <= scm[31:16];
			cm_s3     <= scm[15:0];
			idx_s3    <= idx_s2;

			rs_s4     <= $signed({1'b0, sphere_radius}) * sp_s3;
			rz_s4     <= $signed({1'b0, sphere_radius}) * cp_s3;
			sm_s4     <= sm_s3;
			cm_s4     <= cm_s3;
			idx_s4    <= idx_s3;

			px_s5     <= rs_s4 * cm_s4;
			py_s5     <= rs_s4 * sm_s4;
			rz_s5     <= rz_s4;
			idx_s5    <= idx_s4;

			x_q       <= round_sat(px_s5, 28);
			y_q       <= round_sat(py_s5, 28);
			z_q       <= round_sat({{16{rz_s5[32]}}, rz_s5}, 14);
			idx_q     <= idx_s5;
		end
	end

	assign out_valid = out_vld_q;
	assign vertex_x  = x_q;
	assign vertex_y  = y_q;
	assign vertex_z  = z_q;
	assign tri_out   = idx_q;
endmodule
